>>> rtl/core/deq_pkg.sv
`default_nettype none

package deq_pkg;

	// Default sizing
	localparam int unsigned DEPTH_DEF      = 16;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	// Request codes
	localparam logic [1:0] KIND_PUSH_FRONT = 2'd0;
	localparam logic [1:0] KIND_PUSH_BACK  = 2'd1;
	localparam logic [1:0] KIND_POP_FRONT  = 2'd2;
	localparam logic [1:0] KIND_POP_BACK   = 2'd3;

	// Result status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_REPLY
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;     // capture the request
		logic exec;     // apply the request to pointers, store and cache
		logic capture;  // take the refill word from the store
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_read;  // the request needs a refill read of the store
	} dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/deq_ram.sv
`default_nettype none

module deq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/deq_ctrl.sv
`default_nettype none

module deq_ctrl
	import deq_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd,
	output logic          busy,
	output logic          done
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_next = S_EXEC;
				end
			end
			S_EXEC: begin
				state_next = stat.need_read ? S_READ : S_REPLY;
			end
			S_READ: begin
				state_next = S_REPLY;
			end
			S_REPLY: begin
				state_next = S_IDLE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd         = '0;
		busy        = 1'b1;
		done        = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
			end
			S_READ: begin
				cmd.capture = 1'b1;
			end
			S_REPLY: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/deq_dp.sv
`default_nettype none

module deq_dp
	import deq_pkg::*;
#(
	parameter int unsigned DEPTH      = DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire dp_cmd_t                        cmd,
	output dp_stat_t                            stat,
	input  wire logic [1:0]                     kind,
	input  wire logic [DATA_WIDTH-1:0]          push_value,
	output logic      [DATA_WIDTH-1:0]          popped_value,
	output logic      [1:0]                     status,
	output logic      [$clog2(DEPTH+1)-1:0]     entry_count,
	output logic      [DATA_WIDTH-1:0]          front_value,
	output logic      [DATA_WIDTH-1:0]          back_value
);

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
			input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + {1'b0, off};
		if (sum >= (CW+1)'(DEPTH)) begin
			sum = sum - (CW+1)'(DEPTH);
		end
		return sum[IW-1:0];
	endfunction

	logic [1:0]            kind_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic [IW-1:0]         head_q;
	logic [CW-1:0]         count_q;
	logic [DATA_WIDTH-1:0] front_q;
	logic [DATA_WIDTH-1:0] back_q;
	logic [DATA_WIDTH-1:0] popped_q;
	logic [1:0]            status_q;

	logic                  is_push;
	logic                  is_empty;
	logic                  is_full;
	logic [IW-1:0]         head_inc;
	logic [IW-1:0]         head_dec;
	logic                  ram_we;
	logic [IW-1:0]         ram_waddr;
	logic                  ram_re;
	logic [IW-1:0]         ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;

	assign is_push  = ~kind_q[1];
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CW'(DEPTH));
	assign head_inc = ring_add(head_q, CW'(1));
	assign head_dec = ring_add(head_q, CW'(DEPTH - 1));

	// Refill read only when a pop leaves at least one word behind
	assign stat.need_read = ~is_push & (count_q > CW'(1));

	always_comb begin
		ram_we    = cmd.exec & is_push & ~is_full;
		ram_waddr = (kind_q == KIND_PUSH_FRONT) ? head_dec : ring_add(head_q, count_q);
		ram_re    = cmd.exec & stat.need_read;
		ram_raddr = (kind_q == KIND_POP_FRONT) ? head_inc
			: ring_add(head_q, count_q - CW'(2));
	end

	deq_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(value_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			if (is_push && !is_full) begin
				count_q <= count_q + CW'(1);
				if (kind_q == KIND_PUSH_FRONT) begin
					head_q <= head_dec;
				end
			end else if (!is_push && !is_empty) begin
				count_q <= count_q - CW'(1);
				if (kind_q == KIND_POP_FRONT) begin
					head_q <= head_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			value_q <= push_value;
		end
		if (cmd.exec) begin
			if (is_push) begin
				popped_q <= '0;
				if (is_full) begin
					status_q <= STATUS_FULL;
				end else if (kind_q == KIND_PUSH_FRONT) begin
					status_q <= STATUS_OK;
					front_q  <= value_q;
					if (is_empty) begin
						back_q <= value_q;
					end
				end else begin
					status_q <= STATUS_OK;
					back_q   <= value_q;
					if (is_empty) begin
						front_q <= value_q;
					end
				end
			end else if (is_empty) begin
				popped_q <= '0;
				status_q <= STATUS_EMPTY;
			end else begin
				popped_q <= (kind_q == KIND_POP_FRONT) ? front_q : back_q;
				status_q <= STATUS_OK;
			end
		end
		if (cmd.capture) begin
			if (kind_q == KIND_POP_FRONT) begin
				front_q <= ram_rdata;
			end else begin
				back_q <= ram_rdata;
			end
		end
	end

	assign popped_value = popped_q;
	assign status       = status_q;
	assign entry_count  = count_q;
	assign front_value  = is_empty ? '0 : front_q;
	assign back_value   = is_empty ? '0 : back_q;

endmodule

`default_nettype wire

>>> rtl/core/double_ended_queue.sv
`default_nettype none

// Bounded double-ended queue of signed words kept in a ring store. Raise start
// with kind and push_value while busy is low; that edge is the input transfer.
// Kinds: push front, push back, pop front, pop back. Exactly one result comes
// back per request, on done for a single cycle: the popped word (zero on a
// push or an error), a status (ok, empty, full), the word count after the
// request and the front and back words after it (zero when the queue is
// empty). The receiver cannot stall, so sample the result ports whenever done
// is high. A push, a rejected push, a pop on an empty queue and a pop that
// empties the queue pass through an execute state and then a reply state, in
// which done is raised; a successful pop that leaves words behind passes
// through a read state between them, since the new front or back word must be
// fetched through the store's registered read port. busy falls in the cycle
// after done, so a new request can transfer only once the last one has
// replied. The front and back words live in cache registers, so popping never
// waits on the store for the word it returns.
module double_ended_queue
	import deq_pkg::*;
#(
	parameter int unsigned DEPTH      = DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic        [1:0]                 kind,
	input  wire logic signed [DATA_WIDTH-1:0]      push_value,
	output logic                                   done,
	output logic signed      [DATA_WIDTH-1:0]      popped_value,
	output logic             [1:0]                 status,
	output logic             [$clog2(DEPTH+1)-1:0] entry_count,
	output logic signed      [DATA_WIDTH-1:0]      front_value,
	output logic signed      [DATA_WIDTH-1:0]      back_value
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequence each request: load, execute, optional refill read, reply
	deq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	// Hold pointers, count, cached end words and the ring store
	deq_dp #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.kind        (kind),
		.push_value  (push_value),
		.popped_value(popped_value),
		.status      (status),
		.entry_count (entry_count),
		.front_value (front_value),
		.back_value  (back_value)
	);

endmodule

`default_nettype wire

>>> verif/double_ended_queue_tb.sv
`timescale 1ns / 100ps

module double_ended_queue_tb;
	import deq_pkg::*;

	localparam int unsigned WORD_W  = DATA_WIDTH_DEF;
	localparam int unsigned SLOTS   = DEPTH_DEF;
	localparam int unsigned COUNT_W = $clog2(DEPTH_DEF + 1);
	localparam int unsigned RANDOM_REQUESTS = 1850;

	// One request as the driver sees it: the fields to present, plus how many
	// idle cycles to leave after its transfer before the next start.
	typedef struct {
		logic        [1:0]        kind;
		logic signed [WORD_W-1:0] value;
		int unsigned              idle;
	} request_t;

	// One reply as the block reports it on done.
	typedef struct {
		logic signed [WORD_W-1:0]  popped;
		logic        [1:0]         status;
		logic        [COUNT_W-1:0] count;
		logic signed [WORD_W-1:0]  front;
		logic signed [WORD_W-1:0]  back;
	} reply_t;

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic        [1:0]          kind = KIND_PUSH_FRONT;
	logic signed [WORD_W-1:0]   push_value = '0;
	logic                       done;
	logic signed [WORD_W-1:0]   popped_value;
	logic        [1:0]          status;
	logic        [COUNT_W-1:0]  entry_count;
	logic signed [WORD_W-1:0]   front_value;
	logic signed [WORD_W-1:0]   back_value;

	double_ended_queue #(
		.DEPTH      (SLOTS),
		.DATA_WIDTH (WORD_W)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.push_value   (push_value),
		.done         (done),
		.popped_value (popped_value),
		.status       (status),
		.entry_count  (entry_count),
		.front_value  (front_value),
		.back_value   (back_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: the slowest legal run (about 1950 requests, each followed by the
	// longest idle gap) needs under 1 ms.
	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

	// ------------------------------------------------------------------
	// Deque predictor: a ring of words with a head index and a word count,
	// kept in step with the block by applying every accepted request once.
	// ------------------------------------------------------------------
	logic signed [WORD_W-1:0] ring_words [SLOTS];
	int unsigned              ring_head = 0;
	int unsigned              ring_count = 0;

	request_t queued_requests [$];
	reply_t   awaited_replies [$];
	int unsigned failures = 0;

	// Apply one request to the ring and return the reply the block must give.
	function automatic reply_t apply_request(logic [1:0] req_kind,
	                                         logic signed [WORD_W-1:0] word);
		reply_t      r;
		int unsigned tail;
		r.popped = '0;
		r.status = STATUS_OK;
		case (req_kind)
			KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
				if (ring_count == SLOTS) begin
					// Full: reject, leave the ring untouched.
					r.status = STATUS_FULL;
				end else if (req_kind == KIND_PUSH_FRONT) begin
					ring_head = (ring_head + SLOTS - 1) % SLOTS;
					ring_words[ring_head] = word;
					ring_count++;
				end else begin
					// Push back lands right after the current last word, so on an
					// empty ring it becomes both front and back.
					ring_words[(ring_head + ring_count) % SLOTS] = word;
					ring_count++;
				end
			end
			default: begin
				if (ring_count == 0) begin
					r.status = STATUS_EMPTY;
				end else if (req_kind == KIND_POP_FRONT) begin
					r.popped = ring_words[ring_head];
					ring_head = (ring_head + 1) % SLOTS;
					ring_count--;
				end else begin
					// Pop back removes only the last word.
					r.popped = ring_words[(ring_head + ring_count - 1) % SLOTS];
					ring_count--;
				end
			end
		endcase
		r.count = COUNT_W'(ring_count);
		if (ring_count == 0) begin
			r.front = '0;
			r.back  = '0;
		end else begin
			tail    = (ring_head + ring_count - 1) % SLOTS;
			r.front = ring_words[ring_head];
			r.back  = ring_words[tail];
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Driver: present requests from queued_requests. A transfer happens at an
	// edge where start is high and busy is low; predict the reply right there.
	// Hold the fields while start is high and busy is high. After each
	// transfer wait out the request's idle count before raising start again;
	// a zero count raises start immediately, while the block is still busy.
	// ------------------------------------------------------------------
	int unsigned idle_left = 0;
	int unsigned idle_after = 0;

	always @(posedge clk) begin
		request_t req;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				awaited_replies.push_back(apply_request(kind, push_value));
				idle_left = idle_after;
			end
			// Only a start that is high and refused must hold; otherwise pick
			// the next step, assigning start exactly once in this edge.
			if (!(start && busy)) begin
				if (idle_left > 0) begin
					start <= 1'b0;
					idle_left--;
				end else if (queued_requests.size() > 0) begin
					req = queued_requests.pop_front();
					start      <= 1'b1;
					kind       <= req.kind;
					push_value <= req.value;
					idle_after = req.idle;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: done marks a reply for exactly one cycle and cannot be held
	// off, so take it at every edge where done is high and compare each field
	// with the oldest prediction.
	// ------------------------------------------------------------------
	task automatic report_field(string field, longint expd, longint got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expd, got);
		failures++;
	endtask

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && done) begin
			if (awaited_replies.size() == 0) begin
				$display("%0t: reply with nothing outstanding, expected none, actual %0d",
				         $time, popped_value);
				failures++;
			end else begin
				want = awaited_replies.pop_front();
				if (popped_value !== want.popped)
					report_field("popped_value", want.popped, popped_value);
				if (status !== want.status)
					report_field("status", want.status, status);
				if (entry_count !== want.count)
					report_field("entry_count", want.count, entry_count);
				if (front_value !== want.front)
					report_field("front_value", want.front, front_value);
				if (back_value !== want.back)
					report_field("back_value", want.back, back_value);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic add_request(logic [1:0] req_kind, logic signed [WORD_W-1:0] word,
	                           int unsigned idle);
		request_t req;
		req.kind  = req_kind;
		req.value = word;
		req.idle  = idle;
		queued_requests.push_back(req);
	endtask

	// Mostly short gaps, a few long ones; none at all inside a burst.
	function automatic int unsigned pick_idle(bit burst);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (burst || roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	// Lean on the extremes and small values as well as full random words.
	function automatic logic signed [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return {1'b0, {(WORD_W-1){1'b1}}};
			1: return {1'b1, {(WORD_W-1){1'b0}}};
			2: return '0;
			3: return '1;
			4: return WORD_W'($urandom_range(0, 255));
			5: return -WORD_W'($urandom_range(1, 256));
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int unsigned made;
		int unsigned seg_len;
		int unsigned push_pct;
		bit          burst;
		logic [1:0]  req_kind;

		// Directed: pops on an empty queue, push back onto an empty queue
		// followed by pop back, push front followed by pop front, then fill
		// to capacity and push at both ends while full.
		add_request(KIND_POP_FRONT, '0, 0);
		add_request(KIND_POP_BACK, '1, 2);
		add_request(KIND_PUSH_BACK, {1'b0, {(WORD_W-1){1'b1}}}, 0);
		add_request(KIND_POP_BACK, '0, 1);
		add_request(KIND_PUSH_FRONT, {1'b1, {(WORD_W-1){1'b0}}}, 0);
		add_request(KIND_POP_FRONT, '0, 0);
		for (int i = 0; i < SLOTS; i++)
			add_request((i % 2) ? KIND_PUSH_BACK : KIND_PUSH_FRONT,
			            (i % 3 == 0) ? ~(WORD_W'(1) << (i * 2)) : (WORD_W'(1) << (i * 2 + 1)),
			            i % 4);
		add_request(KIND_PUSH_FRONT, '1, 0);
		add_request(KIND_PUSH_BACK, '0, 0);

		// Random: segments that lean toward pushing, popping or neither, so the
		// count wanders across its whole range and hits full and empty often.
		made = 0;
		while (made < RANDOM_REQUESTS) begin
			seg_len = $urandom_range(8, 60);
			case ($urandom_range(0, 2))
				0: push_pct = 15;
				1: push_pct = 50;
				default: push_pct = 85;
			endcase
			burst = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < seg_len; i++) begin
				if ($urandom_range(0, 99) < push_pct)
					req_kind = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
				else
					req_kind = $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
				add_request(req_kind, pick_word(), pick_idle(burst));
			end
			made += seg_len;
		end

		// Hold reset low, then release it at an edge.
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: every request transferred and every reply seen, then keep watching
		// for any stray done.
		while (queued_requests.size() != 0 || start || awaited_replies.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
